FILE: rtl/tspc_pkg.sv
`default_nettype none
package tspc_pkg;

    typedef enum logic [2:0] {
        REQ_VRAM   = 3'd0,
        REQ_CHAR   = 3'd1,
        REQ_SPRITE = 3'd2,
        REQ_PROM   = 3'd3,
        REQ_QUERY  = 3'd4
    } req_type_t;

    typedef struct packed {
        logic [2:0]  req_type;
        logic [16:0] address;
        logic [7:0]  data;
        logic [7:0]  screen_x;
        logic [7:0]  screen_y;
    } req_t;

    typedef struct packed {
        logic [7:0] red;
        logic [7:0] green;
        logic [7:0] blue;
    } rgb_t;

    localparam logic [11:0] CHAR_CODE_BASE = 12'h800;
    localparam logic [11:0] CHAR_ATTR_BASE = 12'hc00;
    localparam logic [7:0]  SCREEN_LAST_Y  = 8'd191;

    // table sizes are powers of two so that codes wrap by truncation
    localparam int CHAR_TILES      = 2048;
    localparam int SPRITE_PATTERNS = 512;

    function automatic rgb_t expand_color(input logic [7:0] p);
        rgb_t c;
        logic [3:0] r, g, b;
        r = {p[3:2], p[1:0]};
        g = {p[5:4], p[1:0]};
        b = {p[7:6], p[1:0]};
        c.red   = {r, r};
        c.green = {g, g};
        c.blue  = {b, b};
        return c;
    endfunction

    function automatic logic [4:0] prom_entry(input logic [8:0] idx);
        if (idx[3:0] == 4'd1)
            return {idx[8], idx[7:4]};
        else
            return {idx[8], idx[3:0]};
    endfunction

endpackage
`default_nettype wire

FILE: rtl/tspc_pix_mem.sv
`default_nettype none
// Pixel store: 4-bit entries, one write and one read per cycle, registered read.
module tspc_pix_mem #(
    parameter int DEPTH = 131072,
    parameter int AW    = 17
) (
    input  wire logic          clk,
    input  wire logic          we,
    input  wire logic [AW-1:0] waddr,
    input  wire logic [3:0]    wdata,
    input  wire logic [AW-1:0] raddr,
    output logic      [3:0]    rdata
);
    logic [3:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
            mem[waddr] <= wdata;
        rdata <= mem[raddr];
    end
endmodule
`default_nettype wire

FILE: rtl/tile_sprite_pixel_compositor_core.sv
`default_nettype none
// Tile and sprite pixel compositor. Write requests (VRAM, character pixel, sprite pixel,
// PROM) go through S_WRITE and back to idle. A pixel query keeps busy high while the sprite
// table is scanned one entry after another through the single VRAM port, four byte reads
// and one pixel read per sprite. The colour is shown on rgb for one cycle with valid in the
// cycle in which busy falls, so the next request can be taken in that same cycle; the
// result cannot be held off. A query with screen_y past the last line gives no result.
// VRAM is cleared after reset by a pass over all 4096 entries with busy high.
module tile_sprite_pixel_compositor_core #(
    parameter int SPRITE_COUNT    = 64
) (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          start,
    input  wire tspc_pkg::req_t req,
    output logic               busy,
    input  wire logic          cfg_we,
    input  wire logic          cfg_wdata,
    output logic               valid,
    output tspc_pkg::rgb_t     rgb
);
    import tspc_pkg::*;

    localparam int CDEPTH = CHAR_TILES * 64;
    localparam int SDEPTH = SPRITE_PATTERNS * 256;
    localparam int CAW = (CDEPTH > 1) ? $clog2(CDEPTH) : 1;
    localparam int SAW = (SDEPTH > 1) ? $clog2(SDEPTH) : 1;
    localparam int CTW = (CHAR_TILES > 1) ? $clog2(CHAR_TILES) : 1;
    localparam int SPW = (SPRITE_PATTERNS > 1) ? $clog2(SPRITE_PATTERNS) : 1;
    localparam int SCW = (SPRITE_COUNT > 1) ? $clog2(SPRITE_COUNT) : 1;
    localparam logic [SCW:0] LAST_SPR = (SCW+1)'(SPRITE_COUNT - 1);

    typedef enum logic [3:0] {
        S_CLEAR, S_IDLE, S_WRITE, S_CC, S_CA, S_CP, S_S0, S_S1, S_S2, S_S3,
        S_SP, S_SW, S_MIX, S_PROM, S_OUT
    } state_t;

    state_t      state_reg;
    logic        flip_reg;
    req_t        req_reg;
    logic [11:0] clr_reg;
    logic [7:0]  x_reg, y_reg, code_reg, attr_reg, b0_reg, sx_reg, sy_reg;
    logic [3:0]  cpix_reg;
    logic [SCW:0] spr_reg;
    logic        hit_reg;
    logic [7:0]  sidx_reg;
    logic [3:0]  scol_reg;
    logic        svis_reg;
    logic [8:0]  idx_reg;
    rgb_t        rgb_reg;
    logic        valid_reg;

    logic [7:0] vram [4096];
    logic [7:0] prom [32];
    logic [7:0] vram_q, prom_q;
    logic [11:0] vaddr;
    logic        vwe;
    logic [7:0]  vwd;

    logic [9:0]  offs;
    assign offs = {y_reg[7:3] + 5'd4, x_reg[7:3]};

    logic [11:0] sbase;
    assign sbase = 12'(spr_reg[SCW-1 < 0 ? 0 : SCW-1:0]) << 5;

    always_comb
    begin
        vwe = 1'b0;
        vwd = req_reg.data;
        vaddr = req_reg.address[11:0];
        case (state_reg)
            S_CLEAR: begin vwe = 1'b1; vwd = 8'd0; vaddr = clr_reg; end
            S_WRITE: vwe = (req_reg.req_type == REQ_VRAM) && (req_reg.address[16:12] == 5'd0);
            S_CC:    vaddr = CHAR_CODE_BASE | 12'(offs);
            S_CA:    vaddr = CHAR_ATTR_BASE | 12'(offs);
            S_S0:    vaddr = sbase;
            S_S1:    vaddr = sbase | 12'd1;
            S_S2:    vaddr = sbase | 12'd2;
            S_S3:    vaddr = sbase | 12'd3;
            default: ;
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (vwe)
            vram[vaddr] <= vwd;
        vram_q <= vram[vaddr];
        if (state_reg == S_WRITE && req_reg.req_type == REQ_PROM
            && req_reg.address[16:5] == 12'd0)
            prom[req_reg.address[4:0]] <= req_reg.data;
        prom_q <= prom[prom_entry(idx_reg)];
    end

    // sprite geometry from latched bytes (b3 arrives on vram_q in S_SP)
    logic [8:0] dy9;
    logic [7:0] dx;
    logic [3:0] row, col;
    logic       svis;
    assign dy9  = {1'b0, y_reg} + 9'd32 - {1'b0, sy_reg};
    assign dx   = x_reg - sx_reg;
    assign svis = (sy_reg >= 8'd16) && (sy_reg <= 8'd223) && (dy9[8:4] == 5'd0)
                  && (dx[7:4] == 4'd0);
    assign row  = b0_reg[1] ? ~dy9[3:0] : dy9[3:0];
    assign col  = b0_reg[0] ? ~dx[3:0] : dx[3:0];

    logic [8:0] pat9;
    assign pat9 = {vram_q[2:0], b0_reg[7:2]};
    logic [10:0] code11;
    assign code11 = {attr_reg[2:0], code_reg};

    logic          cwe, swe;
    logic [CAW-1:0] craddr;
    logic [SAW-1:0] sraddr;
    logic [3:0]    cq, sq;
    assign cwe = state_reg == S_WRITE && req_reg.req_type == REQ_CHAR
                 && 32'(req_reg.address) < CDEPTH;
    assign swe = state_reg == S_WRITE && req_reg.req_type == REQ_SPRITE
                 && 32'(req_reg.address) < SDEPTH;
    always_comb
    begin
        logic [CTW-1:0] ct;
        logic [SPW-1:0] sp;
        ct = CTW'(code11);
        sp = SPW'(pat9);
        craddr = cwe ? CAW'(req_reg.address)
                     : CAW'({ct, y_reg[2:0], x_reg[2:0]});
        sraddr = swe ? SAW'(req_reg.address) : SAW'({sp, row, col});
    end

    tspc_pix_mem #(.DEPTH(CDEPTH), .AW(CAW)) u_char (
        .clk(clk), .we(cwe), .waddr(CAW'(req_reg.address)),
        .wdata(req_reg.data[3:0]), .raddr(craddr), .rdata(cq));
    tspc_pix_mem #(.DEPTH(SDEPTH), .AW(SAW)) u_spr (
        .clk(clk), .we(swe), .waddr(SAW'(req_reg.address)),
        .wdata(req_reg.data[3:0]), .raddr(sraddr), .rdata(sq));

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_CLEAR;
            clr_reg   <= 12'd0;
            flip_reg  <= 1'b0;
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= 1'b0;
            if (cfg_we)
                flip_reg <= cfg_wdata;
            unique case (state_reg)
                S_CLEAR: begin
                    clr_reg <= clr_reg + 12'd1;
                    if (clr_reg == 12'hfff) state_reg <= S_IDLE;
                end
                S_IDLE: if (start)
                begin
                    req_reg <= req;
                    x_reg <= flip_reg ? ~req.screen_x : req.screen_x;
                    y_reg <= flip_reg ? SCREEN_LAST_Y - req.screen_y : req.screen_y;
                    hit_reg <= 1'b0;
                    spr_reg <= '0;
                    if (req.req_type == REQ_QUERY)
                        state_reg <= (req.screen_y > SCREEN_LAST_Y) ? S_IDLE : S_CC;
                    else
                        state_reg <= S_WRITE;
                end
                S_WRITE: state_reg <= S_IDLE;
                S_CC: state_reg <= S_CA;
                S_CA: begin code_reg <= vram_q; state_reg <= S_CP; end
                S_CP: begin attr_reg <= vram_q; state_reg <= S_S0; end
                S_S0: state_reg <= S_S1;
                S_S1: begin cpix_reg <= cq; b0_reg <= vram_q; state_reg <= S_S2; end
                S_S2: begin sx_reg <= vram_q; state_reg <= S_S3; end
                S_S3: begin sy_reg <= vram_q; state_reg <= S_SP; end
                S_SP: begin
                    svis_reg <= svis;
                    scol_reg <= vram_q[7:4];
                    state_reg <= S_SW;
                end
                S_SW: begin
                    if (svis_reg && sq != 4'd0)
                    begin
                        hit_reg  <= 1'b1;
                        sidx_reg <= {scol_reg, sq};
                    end
                    if (spr_reg == LAST_SPR) state_reg <= S_MIX;
                    else
                    begin
                        spr_reg <= spr_reg + 1'b1;
                        state_reg <= S_S0;
                    end
                end
                S_MIX: begin
                    if (attr_reg[3] && cpix_reg != 4'd0) idx_reg <= {1'b1, attr_reg[7:4], cpix_reg};
                    else if (hit_reg) idx_reg <= {1'b0, sidx_reg};
                    else idx_reg <= {1'b1, attr_reg[7:4], cpix_reg};
                    state_reg <= S_PROM;
                end
                S_PROM: state_reg <= S_OUT;
                S_OUT: begin
                    rgb_reg   <= expand_color(prom_q);
                    valid_reg <= 1'b1;
                    state_reg <= S_IDLE;
                end
                default: state_reg <= S_IDLE;
            endcase
        end
    end

    assign busy  = state_reg != S_IDLE;
    assign valid = valid_reg;
    assign rgb   = rgb_reg;

`ifndef SYNTHESIS
    a_valid_pulse: assert property (@(posedge clk) disable iff (!rst_n)
        valid |=> !valid) else $error("result held over two cycles");
    a_busy_query: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_OUT) |=> valid) else $error("query finished without result");
    a_idle_no_valid: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |=> !valid) else $error("result without query");
`endif
endmodule
`default_nettype wire

FILE: tb/tb.sv
`default_nettype none
module tb;
    import tspc_pkg::*;

    localparam int VRAM_DEPTH    = 4096;
    localparam int PROM_DEPTH    = 32;
    localparam int PIX_DEPTH     = 131072;
    localparam int SPRITE_SLOTS  = 64;
    localparam int SPRITE_STRIDE = 32;
    localparam int SPRITE_Y_MIN  = 16;
    localparam int SPRITE_Y_MAX  = 223;
    localparam int SPRITE_Y_BIAS = 32;
    localparam int REQ_CODE_MAX  = 7;
    localparam int SETTLE        = 400;
    localparam int WATCHDOG      = 20000;
    localparam int REPORT_MAX    = 10;
    localparam int PHASE_ITEMS   = 100;

    logic clk;
    logic rst_n;
    logic start;
    req_t req;
    logic busy;
    logic cfg_we;
    logic cfg_wdata;
    logic valid;
    rgb_t rgb;

    tile_sprite_pixel_compositor_core u_dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (start),
        .req      (req),
        .busy     (busy),
        .cfg_we   (cfg_we),
        .cfg_wdata(cfg_wdata),
        .valid    (valid),
        .rgb      (rgb)
    );

    // requests waiting to be issued, colours waiting to come back
    req_t pending_reqs[$];
    rgb_t expected_rgb[$];
    logic req_taken;
    int   sender_idle;
    int   fail_count;
    int   quiet_cycles;

    // shadow state used to plan fills ahead of queries
    logic [7:0] plan_vram [VRAM_DEPTH];
    bit         char_loaded [PIX_DEPTH];
    bit         sprite_loaded [PIX_DEPTH];
    logic       plan_flip;

    // compositor state as seen by accepted requests
    logic [7:0] vram_q [VRAM_DEPTH];
    logic [3:0] char_pix [PIX_DEPTH];
    logic [3:0] sprite_pix [PIX_DEPTH];
    logic [7:0] prom_q [PROM_DEPTH];
    logic       flip_q;

    function automatic logic [11:0] tile_offset(input logic [7:0] x, input logic [7:0] y);
        logic [4:0] row;
        row = y[7:3] + 5'd4;
        return {2'b00, row, x[7:3]};
    endfunction

    function automatic logic [16:0] char_pix_addr(input logic [7:0] code_lo,
                                                  input logic [7:0] attr,
                                                  input logic [7:0] x, input logic [7:0] y);
        return {attr[2:0], code_lo, y[2:0], x[2:0]};
    endfunction

    function automatic bit sprite_covers(input logic [7:0] b0, input logic [7:0] sx,
                                         input logic [7:0] sy, input logic [7:0] b3,
                                         input logic [7:0] x, input logic [7:0] y,
                                         output logic [16:0] pix_addr);
        int         dy;
        logic [7:0] dx;
        logic [3:0] row, col;
        pix_addr = '0;
        if (sy < SPRITE_Y_MIN || sy > SPRITE_Y_MAX)
            return 0;
        dy = int'(y) - (int'(sy) - SPRITE_Y_BIAS);
        if (dy < 0 || dy > 15)
            return 0;
        dx = x - sx;
        if (dx > 8'd15)
            return 0;
        row = b0[1] ? 4'(15 - dy) : 4'(dy);
        col = b0[0] ? 4'd15 - dx[3:0] : dx[3:0];
        pix_addr = {b3[2:0], b0[7:2], row, col};
        return 1;
    endfunction

    function automatic rgb_t pixel_colour(input logic [7:0] qx, input logic [7:0] qy);
        logic [7:0]  x, y, attr, p;
        logic [11:0] offs;
        logic [16:0] a;
        logic [3:0]  cpix, pix, rn, gn, bn;
        logic [8:0]  cidx, sidx, idx;
        logic [4:0]  e;
        bit          hit;
        rgb_t        c;
        x = flip_q ? 8'd255 - qx : qx;
        y = flip_q ? SCREEN_LAST_Y - qy : qy;
        offs = tile_offset(x, y);
        attr = vram_q[CHAR_ATTR_BASE + offs];
        cpix = char_pix[char_pix_addr(vram_q[CHAR_CODE_BASE + offs], attr, x, y)];
        cidx = {1'b1, attr[7:4], cpix};
        hit = 0;
        sidx = '0;
        for (int i = 0; i < SPRITE_SLOTS; i++) begin
            if (sprite_covers(vram_q[i*SPRITE_STRIDE], vram_q[i*SPRITE_STRIDE+1],
                              vram_q[i*SPRITE_STRIDE+2], vram_q[i*SPRITE_STRIDE+3],
                              x, y, a)) begin
                pix = sprite_pix[a];
                if (pix != 4'd0)
                begin
                    hit = 1;
                    sidx = {1'b0, vram_q[i*SPRITE_STRIDE+3][7:4], pix};
                end
            end
        end
        if (attr[3] && cpix != 4'd0)
            idx = cidx;
        else if (hit)
            idx = sidx;
        else
            idx = cidx;
        e = (idx[3:0] == 4'd1) ? {idx[8], idx[7:4]} : {idx[8], idx[3:0]};
        p = prom_q[e];
        rn = {p[3:2], p[1:0]};
        gn = {p[5:4], p[1:0]};
        bn = {p[7:6], p[1:0]};
        c.red   = 8'(rn * 8'h11);
        c.green = 8'(gn * 8'h11);
        c.blue  = 8'(bn * 8'h11);
        return c;
    endfunction

    function automatic void apply_request(input req_t r);
        case (r.req_type)
            REQ_VRAM:   if (r.address < VRAM_DEPTH) vram_q[r.address] = r.data;
            REQ_CHAR:   char_pix[r.address] = r.data[3:0];
            REQ_SPRITE: sprite_pix[r.address] = r.data[3:0];
            REQ_PROM:   if (r.address < PROM_DEPTH) prom_q[r.address] = r.data;
            REQ_QUERY:  if (r.screen_y <= SCREEN_LAST_Y)
                            expected_rgb.push_back(pixel_colour(r.screen_x, r.screen_y));
            default: ;
        endcase
    endfunction

    function automatic void note_fail(input string msg);
        fail_count++;
        if (fail_count <= REPORT_MAX)
            $display("%0t: %s", $realtime, msg);
    endfunction

    // ---------------- request generation ----------------

    function automatic req_t make_req(input logic [2:0] t, input logic [16:0] a,
                                      input logic [7:0] d, input logic [7:0] x,
                                      input logic [7:0] y);
        req_t r;
        r.req_type = t;
        r.address  = a;
        r.data     = d;
        r.screen_x = x;
        r.screen_y = y;
        return r;
    endfunction

    function automatic void push_req(input req_t r);
        pending_reqs.push_back(r);
        case (r.req_type)
            REQ_VRAM:   if (r.address < VRAM_DEPTH) plan_vram[r.address] = r.data;
            REQ_CHAR:   char_loaded[r.address] = 1;
            REQ_SPRITE: sprite_loaded[r.address] = 1;
            default: ;
        endcase
    endfunction

    function automatic logic [7:0] pix_byte();
        logic [7:0] d;
        d = 8'($urandom);
        if ($urandom_range(2) == 0)
            d[3:0] = 4'd0;
        return d;
    endfunction

    function automatic logic [7:0] rand_x();
        return 8'($urandom);
    endfunction

    function automatic void push_write(input logic [2:0] t, input logic [16:0] a,
                                       input logic [7:0] d);
        push_req(make_req(t, a, d, rand_x(), rand_x()));
    endfunction

    // loads any pixel the query would read that has not been written yet
    function automatic void push_query(input logic [7:0] qx, input logic [7:0] qy);
        logic [7:0]  x, y;
        logic [11:0] offs;
        logic [16:0] a;
        if (qy <= SCREEN_LAST_Y) begin
            x = plan_flip ? 8'd255 - qx : qx;
            y = plan_flip ? SCREEN_LAST_Y - qy : qy;
            offs = tile_offset(x, y);
            a = char_pix_addr(plan_vram[CHAR_CODE_BASE + offs],
                              plan_vram[CHAR_ATTR_BASE + offs], x, y);
            if (!char_loaded[a])
                push_write(REQ_CHAR, a, pix_byte());
            for (int i = 0; i < SPRITE_SLOTS; i++)
                if (sprite_covers(plan_vram[i*SPRITE_STRIDE], plan_vram[i*SPRITE_STRIDE+1],
                                  plan_vram[i*SPRITE_STRIDE+2], plan_vram[i*SPRITE_STRIDE+3],
                                  x, y, a) && !sprite_loaded[a])
                    push_write(REQ_SPRITE, a, pix_byte());
        end
        push_req(make_req(REQ_QUERY, 17'($urandom), 8'($urandom), qx, qy));
    endfunction

    // screen-space pixel on a randomly chosen sprite, mapped through the current flip
    function automatic void push_sprite_query();
        int         i;
        logic [7:0] x, sy;
        int         y;
        i  = $urandom_range(SPRITE_SLOTS - 1);
        sy = plan_vram[i*SPRITE_STRIDE+2];
        x  = plan_vram[i*SPRITE_STRIDE+1] + 8'($urandom_range(15));
        y  = int'(sy) - SPRITE_Y_BIAS + $urandom_range(15);
        if (y < 0 || y > SCREEN_LAST_Y)
            y = $urandom_range(SCREEN_LAST_Y);
        if (plan_flip)
            push_query(8'd255 - x, SCREEN_LAST_Y - 8'(y));
        else
            push_query(x, 8'(y));
    endfunction

    function automatic void push_sprite_write();
        int         i, k;
        logic [7:0] d;
        i = $urandom_range(SPRITE_SLOTS - 1);
        k = $urandom_range(3);
        d = 8'($urandom);
        if (k == 1 && $urandom_range(4) != 0)
            d = 8'($urandom_range(100, 140));
        if (k == 2 && $urandom_range(4) != 0)
            d = 8'($urandom_range(40, 100));
        push_write(REQ_VRAM, 17'(i*SPRITE_STRIDE + k), d);
    endfunction

    function automatic void push_random_item();
        int r;
        r = $urandom_range(99);
        if (r < 35)
            push_sprite_query();
        else if (r < 45)
            push_query(rand_x(), 8'($urandom_range(SCREEN_LAST_Y)));
        else if (r < 62)
            push_sprite_write();
        else if (r < 75)
            push_write(REQ_VRAM, 17'($urandom_range(CHAR_CODE_BASE + 128, VRAM_DEPTH - 1)),
                       8'($urandom));
        else if (r < 79)
            push_write(REQ_PROM, 17'($urandom_range(PROM_DEPTH - 1)), 8'($urandom));
        else if (r < 80)
            push_write(REQ_PROM, 17'($urandom_range(PROM_DEPTH, PIX_DEPTH - 1)), 8'($urandom));
        else if (r < 86)
            push_write(REQ_CHAR, 17'($urandom), pix_byte());
        else if (r < 92)
            push_write(REQ_SPRITE, 17'($urandom), pix_byte());
        else if (r < 95)
            push_write(REQ_VRAM, 17'($urandom), 8'($urandom));
        else if (r < 98)
            push_write(3'($urandom_range(int'(REQ_QUERY) + 1, REQ_CODE_MAX)),
                       17'($urandom), 8'($urandom));
        else
            push_query(rand_x(), rand_x());
    endfunction

    task automatic wait_idle();
        while (pending_reqs.size() != 0 || start || busy || expected_rgb.size() != 0)
            @(posedge clk);
        repeat (SETTLE) @(posedge clk);
    endtask

    task automatic write_flip(input logic v);
        @(negedge clk);
        cfg_we    <= 1'b1;
        cfg_wdata <= v;
        @(negedge clk);
        cfg_we    <= 1'b0;
        flip_q    = v;
        plan_flip = v;
    endtask

    // ---------------- clock, reset, driver, monitor ----------------

    initial begin
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    always @(negedge clk) begin
        if (!rst_n)
            start <= 1'b0;
        else if (start && !req_taken)
            ;
        else if (pending_reqs.size() != 0 && $urandom_range(99) >= sender_idle) begin
            req   <= pending_reqs.pop_front();
            start <= 1'b1;
        end
        else
            start <= 1'b0;
    end

    always @(posedge clk or negedge rst_n) begin
        rgb_t want;
        if (!rst_n) begin
            req_taken    <= 1'b0;
            quiet_cycles <= 0;
        end
        else begin
            if (valid) begin
                if (expected_rgb.size() == 0)
                    note_fail($sformatf("colour %h with no query outstanding", rgb));
                else begin
                    want = expected_rgb.pop_front();
                    if (rgb.red !== want.red || rgb.green !== want.green ||
                        rgb.blue !== want.blue)
                        note_fail($sformatf("rgb exp %h/%h/%h got %h/%h/%h",
                                            want.red, want.green, want.blue,
                                            rgb.red, rgb.green, rgb.blue));
                end
            end
            if (start && !busy)
                apply_request(req);
            req_taken    <= start && !busy;
            quiet_cycles <= (valid || (start && !busy)) ? 0 : quiet_cycles + 1;
            if (quiet_cycles >= WATCHDOG) begin
                $display("tile_sprite_pixel_compositor_core: mismatch");
                $finish;
            end
        end
    end

    // ---------------- stimulus ----------------

    initial begin
        start       = 1'b0;
        req         = '0;
        cfg_we      = 1'b0;
        cfg_wdata   = 1'b0;
        rst_n       = 1'b0;
        sender_idle = 11;
        fail_count  = 0;
        flip_q      = 1'b0;
        plan_flip   = 1'b0;
        for (int i = 0; i < VRAM_DEPTH; i++) begin
            plan_vram[i] = '0;
            vram_q[i]    = '0;
        end
        repeat (3) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        wait_idle();
        write_flip(1'b0);

        for (int i = 0; i < PROM_DEPTH; i++)
            push_write(REQ_PROM, 17'(i), 8'($urandom));

        // ignored writes and requests
        push_write(REQ_PROM, 17'(PROM_DEPTH), 8'hff);
        push_write(REQ_PROM, 17'h1ffff, 8'h00);
        push_write(REQ_VRAM, 17'(VRAM_DEPTH), 8'hff);
        push_write(REQ_VRAM, 17'h1ffff, 8'hff);
        for (int t = int'(REQ_QUERY) + 1; t <= REQ_CODE_MAX; t++)
            push_write(3'(t), 17'h1ffff, 8'hff);
        push_query(8'd0, SCREEN_LAST_Y + 8'd1);
        push_query(8'd255, 8'd255);

        // two overlapping sprites wrapping off the right edge, last one wins
        push_write(REQ_VRAM, 17'd0, 8'hff);
        push_write(REQ_VRAM, 17'd1, 8'd250);
        push_write(REQ_VRAM, 17'd2, 8'd60);
        push_write(REQ_VRAM, 17'd3, 8'ha7);
        push_write(REQ_VRAM, 17'((SPRITE_SLOTS-1)*SPRITE_STRIDE),     8'h04);
        push_write(REQ_VRAM, 17'((SPRITE_SLOTS-1)*SPRITE_STRIDE + 1), 8'd252);
        push_write(REQ_VRAM, 17'((SPRITE_SLOTS-1)*SPRITE_STRIDE + 2), 8'd62);
        push_write(REQ_VRAM, 17'((SPRITE_SLOTS-1)*SPRITE_STRIDE + 3), 8'h50);
        // sprites at the y limits and one just past them, which is hidden
        push_write(REQ_VRAM, 17'(5*SPRITE_STRIDE + 2), 8'(SPRITE_Y_MAX + 1));
        push_write(REQ_VRAM, 17'(6*SPRITE_STRIDE + 2), 8'(SPRITE_Y_MIN));
        push_write(REQ_VRAM, 17'(7*SPRITE_STRIDE + 2), 8'(SPRITE_Y_MAX));
        // priority character, top tile code
        push_write(REQ_VRAM, 17'(CHAR_CODE_BASE + 255), 8'hff);
        push_write(REQ_VRAM, 17'(CHAR_ATTR_BASE + 255), 8'h8f);
        push_query(8'd252, 8'd28);
        push_query(8'd250, 8'd30);
        push_query(8'd2, 8'd30);
        push_query(8'd0, 8'd0);
        push_query(8'd255, SCREEN_LAST_Y);
        push_query(8'd3, SCREEN_LAST_Y);

        for (int n = 0; n < PHASE_ITEMS; n++)
            push_random_item();
        wait_idle();

        write_flip(1'b1);
        sender_idle = 67;
        for (int n = 0; n < PHASE_ITEMS; n++)
            push_random_item();
        wait_idle();

        write_flip(1'b0);
        sender_idle = 0;
        for (int n = 0; n < PHASE_ITEMS; n++)
            push_random_item();
        wait_idle();

        if (expected_rgb.size() != 0)
            note_fail("queries left without a colour");
        if (fail_count == 0)
            $display("tile_sprite_pixel_compositor_core: match");
        else
            $display("tile_sprite_pixel_compositor_core: mismatch");
        $finish;
    end

endmodule
`default_nettype wire

FILE: sim.f
rtl/tspc_pkg.sv
rtl/tspc_pix_mem.sv
rtl/tile_sprite_pixel_compositor_core.sv
tb/tb.sv
